// File: rtl/core/led_fade_blink_controller_assert.svh
// Assertion macros shared by the LED fade controller RTL.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
`ifndef LED_FADE_BLINK_CONTROLLER_ASSERT_SVH
`define LED_FADE_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define LFBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("led_fade_blink_controller: assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define LFBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("led_fade_blink_controller: assertion failed");

`endif

// File: rtl/core/lfbc_pkg.sv
// ----------------------------------------------------------------------------
// lfbc_pkg
// Types, codes and constants shared by the LED fade controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbc_pkg;

    // Resolution of the PWM channel; written values are masked to this width.
    localparam int LEVEL_BITS = 15;
    localparam logic [14:0] LEVEL_MASK = 15'((17'd1 << LEVEL_BITS) - 17'd1);

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic signed [15:0] REPEATS_ENDLESS = -16'sd1;
    localparam logic signed [15:0] REPEATS_LAST = 16'sd1;

    // Command codes of the func field.
    localparam logic [2:0] FUNC_TICK        = 3'd0;
    localparam logic [2:0] FUNC_LIGHT_UP    = 3'd1;
    localparam logic [2:0] FUNC_TURN_OFF    = 3'd2;
    localparam logic [2:0] FUNC_SET_LEVEL   = 3'd3;
    localparam logic [2:0] FUNC_RUN_FOREVER = 3'd4;
    localparam logic [2:0] FUNC_RUN_COUNT   = 3'd5;
    localparam logic [2:0] FUNC_RAMP_UP     = 3'd6;
    localparam logic [2:0] FUNC_RAMP_DOWN   = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_LEVEL     = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE     = 2'd1;
    localparam logic [1:0] CFG_TICK_INTERVAL = 2'd2;

    // Configuration reset values.
    localparam logic [14:0] MAX_LEVEL_RESET     = 15'h7FFF;
    localparam logic [7:0]  STEP_SIZE_RESET     = 8'd1;
    localparam logic [15:0] TICK_INTERVAL_RESET = 16'd1;

    typedef struct packed {
        logic [14:0] max_level;
        logic [7:0]  step_size;
        logic [15:0] tick_interval;
    } t_cfg;

    typedef struct packed {
        logic [14:0]        level;
        logic               fade_upward;
        logic               breathe_active;
        logic               ramp_up_active;
        logic               ramp_down_active;
        logic signed [15:0] repeats_left;
        logic [16:0]        elapsed;
    } t_state;

    typedef struct packed {
        logic [14:0] pwm_level;
        logic        level_written;
        logic        busy_res;
    } t_result;

    // State after everything has been stopped: dark, upward, no mode running.
    function automatic t_state f_idle_state(input logic [15:0] tick_interval);
        t_state s;
        s.level            = '0;
        s.fade_upward      = 1'b1;
        s.breathe_active   = 1'b0;
        s.ramp_up_active   = 1'b0;
        s.ramp_down_active = 1'b0;
        s.repeats_left     = REPEATS_ENDLESS;
        s.elapsed          = {1'b0, tick_interval};
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lfbc_step.sv
// ----------------------------------------------------------------------------
// lfbc_step
// Next-state and result logic for one tick or command word.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbc_step
    import lfbc_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  logic [2:0]  i_func,
    input  logic [14:0] i_level_value,
    input  logic [14:0] i_repeat_count,
    output t_state      o_state,
    output t_result     o_result
);

    logic [16:0]        elapsed_inc;
    logic               step_due;
    logic [15:0]        up_sum;
    logic               up_hit;
    logic [16:0]        down_diff;
    logic               down_pos;
    logic signed [15:0] repeats_dec;
    logic               any_active;
    logic               repeats_many;
    logic               finish_block;

    assign elapsed_inc  = (i_state.elapsed == ELAPSED_MAX) ? i_state.elapsed
                                                          : i_state.elapsed + 17'd1;
    // A step is due once the advanced counter exceeds the interval.
    assign step_due     = elapsed_inc > {1'b0, i_cfg.tick_interval};
    assign up_sum       = {1'b0, i_state.level} + {8'd0, i_cfg.step_size};
    assign up_hit       = up_sum >= {1'b0, i_cfg.max_level};
    assign down_diff    = {2'b00, i_state.level} - {9'd0, i_cfg.step_size};
    assign down_pos     = !down_diff[16] && (down_diff != 17'd0);
    assign repeats_dec  = i_state.repeats_left - 16'sd1;
    assign any_active   = i_state.breathe_active || i_state.ramp_up_active
                          || i_state.ramp_down_active;
    assign repeats_many = i_state.repeats_left > REPEATS_LAST;
    // Earlier work that has to run to its end refuses a new mode.
    assign finish_block = repeats_many || i_state.ramp_up_active || i_state.ramp_down_active
                          || (i_state.breathe_active && i_state.repeats_left[15]);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_func)
            FUNC_TICK: begin
                o_result.busy_res = any_active;
                // At most one step per tick: any step leaves the counter at or
                // below the interval, so later modes see no step due.
                priority if (i_state.breathe_active && step_due) begin
                    o_state.elapsed = '0;
                    if (i_state.fade_upward) begin
                        if (up_hit) begin
                            o_state.level       = i_cfg.max_level;
                            o_state.fade_upward = 1'b0;
                        end else begin
                            o_state.level = up_sum[14:0];
                        end
                    end else if (down_pos) begin
                        o_state.level = down_diff[14:0];
                    end else begin
                        o_state.level       = '0;
                        o_state.fade_upward = 1'b1;
                        if (!i_state.repeats_left[15]) begin
                            o_state.repeats_left = repeats_dec;
                            if (repeats_dec == 16'sd0) begin
                                o_state = f_idle_state(i_cfg.tick_interval);
                            end
                        end
                    end
                    o_result.level_written = 1'b1;
                    o_result.pwm_level     = o_state.level & LEVEL_MASK;
                end else if (i_state.ramp_up_active && step_due) begin
                    if (up_hit) begin
                        o_state.level          = i_cfg.max_level;
                        o_state.ramp_up_active = 1'b0;
                        o_state.elapsed        = {1'b0, i_cfg.tick_interval};
                    end else begin
                        o_state.level   = up_sum[14:0];
                        o_state.elapsed = '0;
                    end
                    o_result.level_written = 1'b1;
                    o_result.pwm_level     = o_state.level & LEVEL_MASK;
                end else if (i_state.ramp_down_active && step_due) begin
                    if (down_pos) begin
                        o_state.level   = down_diff[14:0];
                        o_state.elapsed = '0;
                    end else begin
                        o_state.level            = '0;
                        o_state.ramp_down_active = 1'b0;
                        o_state.elapsed          = {1'b0, i_cfg.tick_interval};
                    end
                    o_result.level_written = 1'b1;
                    o_result.pwm_level     = o_state.level & LEVEL_MASK;
                end else begin
                    o_state.elapsed = elapsed_inc;
                end
            end
            FUNC_LIGHT_UP: begin
                o_state                = f_idle_state(i_cfg.tick_interval);
                o_result.level_written = 1'b1;
                o_result.pwm_level     = LEVEL_MASK;
            end
            FUNC_TURN_OFF: begin
                o_state                = f_idle_state(i_cfg.tick_interval);
                o_result.level_written = 1'b1;
            end
            FUNC_SET_LEVEL: begin
                o_state                = f_idle_state(i_cfg.tick_interval);
                o_state.level          = i_level_value & LEVEL_MASK;
                o_result.level_written = 1'b1;
                o_result.pwm_level     = i_level_value & LEVEL_MASK;
            end
            FUNC_RUN_FOREVER: begin
                if (repeats_many) begin
                    o_state.repeats_left = REPEATS_LAST;
                end else if (!finish_block) begin
                    o_state.breathe_active = 1'b1;
                    o_state.repeats_left   = REPEATS_ENDLESS;
                end
            end
            FUNC_RUN_COUNT: begin
                if (i_state.repeats_left[15]) begin
                    o_state.repeats_left   = {1'b0, i_repeat_count};
                    o_state.breathe_active = 1'b1;
                end
            end
            FUNC_RAMP_UP: begin
                if (repeats_many) begin
                    o_state.repeats_left = REPEATS_LAST;
                end else if (!finish_block && (i_state.level < i_cfg.max_level)) begin
                    o_state.ramp_up_active = 1'b1;
                end
            end
            FUNC_RAMP_DOWN: begin
                if (repeats_many) begin
                    o_state.repeats_left = REPEATS_LAST;
                end else if (!finish_block && (i_state.level != 15'd0)) begin
                    o_state.ramp_down_active = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/led_fade_blink_controller.sv
// ----------------------------------------------------------------------------
// led_fade_blink_controller
// Brightness controller for one PWM-driven LED with fades, ramps and breathing.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Word
//  in        sink       i_in_valid / o_in_stall  func, level_value, repeat_count
//  out       source     o_out_valid / i_out_stall pwm_level, level_written, busy_res
//  cfg       sink       i_cfg_valid / o_cfg_ready register index, write data
//
// Every input word is handled at the edge that accepts it: the controller
// state is updated and the result word is captured in the output register,
// or in the skid register when the output register is full, so one word per
// cycle is sustained while o_in_stall is low. A skid register behind the
// output register lets a second word be accepted while the first result is
// still stalled; o_in_stall rises only when both are full. Reset is
// synchronous and returns the configuration registers and the fade state
// to their defaults. Configuration writes are always taken.
//
`default_nettype none
`include "led_fade_blink_controller_assert.svh"

module led_fade_blink_controller
    import lfbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [14:0] i_level_value,
    input  logic [14:0] i_repeat_count,
    // Result word channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [14:0] o_pwm_level,
    output logic        o_level_written,
    output logic        o_busy_res,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic    in_accept;
    logic    out_take;

    // The step logic sees the current state and produces the state and the
    // result word for the item presented at the input.
    lfbc_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_func         (i_func),
        .i_level_value  (i_level_value),
        .i_repeat_count (i_repeat_count),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Only a full skid register holds the input back.
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_level     <= MAX_LEVEL_RESET;
            r_cfg.step_size     <= STEP_SIZE_RESET;
            r_cfg.tick_interval <= TICK_INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_LEVEL:     r_cfg.max_level     <= i_cfg_data[14:0];
                CFG_STEP_SIZE:     r_cfg.step_size     <= i_cfg_data[7:0];
                CFG_TICK_INTERVAL: r_cfg.tick_interval <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Fade state advances once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_idle_state(TICK_INTERVAL_RESET);
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register and skid register valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            // The skid word, when present, moves up; otherwise a new word may
            // take the freed place directly.
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Result payloads carry no reset.
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= n_result;
            end
        end else if (in_accept) begin
            if (r_out_valid) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pwm_level     = r_out.pwm_level;
    assign o_level_written = r_out.level_written;
    assign o_busy_res      = r_out.busy_res;

    // The skid register is only ever filled behind a full output register.
    `LFBC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    // A word accepted while the output is stalled must land in the skid register.
    `LFBC_ASSERT_NEXT(a_skid_fill, in_accept && r_out_valid && i_out_stall, r_skid_valid)
    // The two ramps refuse each other, so they never run together.
    `LFBC_ASSERT_NOW(a_one_ramp, r_state.ramp_up_active, !r_state.ramp_down_active)
    // The repeat count is either endless or a non-negative count.
    `LFBC_ASSERT_NOW(a_repeats_range, r_state.repeats_left[15],
                     r_state.repeats_left == REPEATS_ENDLESS)

endmodule

`default_nettype wire
